// ===== rtl/core/jvmbd_pkg.sv =====
// Package of the bytecode decoder: request and result types, operand forms, switch phases.
`default_nettype none
package jvmbd_pkg;

  localparam int POS_BITS = 16;

  localparam logic [7:0] OP_BIPUSH       = 8'h10;
  localparam logic [7:0] OP_SIPUSH       = 8'h11;
  localparam logic [7:0] OP_LDC          = 8'h12;
  localparam logic [7:0] OP_IFEQ         = 8'h99;
  localparam logic [7:0] OP_JSR          = 8'ha8;
  localparam logic [7:0] OP_IINC         = 8'h84;
  localparam logic [7:0] OP_TABLESWITCH  = 8'haa;
  localparam logic [7:0] OP_LOOKUPSWITCH = 8'hab;
  localparam logic [7:0] OP_INVOKEIFACE  = 8'hb9;
  localparam logic [7:0] OP_NEWARRAY     = 8'hbc;
  localparam logic [7:0] OP_MULTIANEW    = 8'hc5;
  localparam logic [7:0] OP_GOTO_W       = 8'hc8;

  typedef enum logic [3:0] {
    F_NONE    = 4'd0,
    F_BYTE    = 4'd1,
    F_POOL16  = 4'd2,
    F_IMM16   = 4'd3,
    F_IINC    = 4'd4,
    F_BR16    = 4'd5,
    F_BR32    = 4'd6,
    F_IFACE   = 4'd7,
    F_MULTI   = 4'd8,
    F_TBLHDR  = 4'd9,
    F_LKPHDR  = 4'd10,
    F_ENTRY   = 4'd11,
    F_UNKNOWN = 4'd12
  } form_t;

  typedef enum logic [7:0] {
    PH_IDLE    = 8'b0000_0001,
    PH_PAD     = 8'b0000_0010,
    PH_DEFAULT = 8'b0000_0100,
    PH_LOW     = 8'b0000_1000,
    PH_HIGH    = 8'b0001_0000,
    PH_TBL_OFS = 8'b0010_0000,
    PH_LKP_KEY = 8'b0100_0000,
    PH_LKP_OFS = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    form_t      form;
    logic [2:0] len;
  } cls_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       code_last;
  } in_req_t;

  typedef struct packed {
    logic [15:0]        start_offset;
    logic [7:0]         opcode;
    form_t              form;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] branch_target;
    logic               cut_short;
  } out_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/jvm_bytecode_decoder.sv =====
// Top level of the bytecode decoder: per-byte instruction framing and operand decode.
`default_nettype none
// The decoder takes one code byte per cycle (in_data.code_byte, with
// in_data.code_last on the final byte of a method) and gives at most one
// result request per byte: the instruction's start offset, opcode, operand
// form and decoded operands. Each byte is decoded in a single pass of
// combinational logic from the decoder state registers into an output
// register, so a new byte is taken every cycle; the output register lets the
// next byte in while a result still waits, and in_ready drops only when a
// result is held and out_ready is low. Each result is registered: it appears
// in the cycle after the byte that completes its instruction. tableswitch and
// lookupswitch give one header result and then one result per entry; switch
// padding aligns to 4 bytes of code offset. A method that ends mid-instruction
// produces a result flagged cut_short. Offsets wrap at POS_BITS bits.
module jvm_bytecode_decoder
  import jvmbd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_req_t  in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_req_t      out_data
);

  // decoder state
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [7:0]          op_r, op_nxt;
  form_t               form_r, form_nxt;
  logic [2:0]          left_r, left_nxt;
  logic [1:0]          pad_r, pad_nxt;
  logic [31:0]         gather_r, gather_nxt;
  logic [31:0]         held_op_r, held_op_nxt;
  logic [31:0]         held_def_r, held_def_nxt;
  logic [31:0]         ent_left_r, ent_left_nxt;
  logic [31:0]         key_r, key_nxt;
  phase_t              phase_r, phase_nxt;

  // result register
  logic                out_valid_r;
  out_req_t            out_data_r;

  // per-byte decode
  logic                accept;
  logic                emit;
  out_req_t            res;
  logic [7:0]          b;
  logic                last;
  logic [31:0]         g;
  logic [2:0]          left_dec;
  logic [31:0]         start32;
  logic [31:0]         cnt_sat;
  logic signed [33:0]  cnt;
  cls_t                cls;

  function automatic cls_t classify(input logic [7:0] op);
    cls_t c;
    c.form = F_UNKNOWN;
    c.len  = 3'd0;
    case (op) inside
      [8'h00:8'h0f], [8'h1a:8'h35], [8'h3b:8'h83], [8'h85:8'h98], [8'hac:8'hb1],
      8'hbe, 8'hbf, 8'hc2, 8'hc3: begin
        c.form = F_NONE;
      end
      OP_BIPUSH, OP_LDC, [8'h15:8'h19], [8'h36:8'h3a], 8'ha9, OP_NEWARRAY: begin
        c.form = F_BYTE;
        c.len  = 3'd1;
      end
      OP_SIPUSH: begin
        c.form = F_IMM16;
        c.len  = 3'd2;
      end
      8'h13, 8'h14, [8'hb2:8'hb8], 8'hbb, 8'hbd, 8'hc0, 8'hc1: begin
        c.form = F_POOL16;
        c.len  = 3'd2;
      end
      OP_IINC: begin
        c.form = F_IINC;
        c.len  = 3'd2;
      end
      [OP_IFEQ:OP_JSR], 8'hc6, 8'hc7: begin
        c.form = F_BR16;
        c.len  = 3'd2;
      end
      OP_GOTO_W, 8'hc9: begin
        c.form = F_BR32;
        c.len  = 3'd4;
      end
      OP_INVOKEIFACE: begin
        c.form = F_IFACE;
        c.len  = 3'd4;
      end
      OP_MULTIANEW: begin
        c.form = F_MULTI;
        c.len  = 3'd3;
      end
      OP_TABLESWITCH: begin
        c.form = F_TBLHDR;
      end
      OP_LOOKUPSWITCH: begin
        c.form = F_LKPHDR;
      end
      default: begin
        c.form = F_UNKNOWN;
      end
    endcase
    return c;
  endfunction

  // take a byte unless a result is held and not being taken
  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    pos_nxt      = pos_r;
    start_nxt    = start_r;
    op_nxt       = op_r;
    form_nxt     = form_r;
    left_nxt     = left_r;
    pad_nxt      = pad_r;
    gather_nxt   = gather_r;
    held_op_nxt  = held_op_r;
    held_def_nxt = held_def_r;
    ent_left_nxt = ent_left_r;
    key_nxt      = key_r;
    phase_nxt    = phase_r;
    emit         = 1'b0;
    res          = '0;

    b        = in_data.code_byte;
    last     = in_data.code_last;
    g        = {gather_r[23:0], b};
    left_dec = left_r - 3'd1;
    start32  = 32'(start_r);
    cls      = classify(b);

    // signed high - low + 1, clamped to 0 .. 0xFFFFFFFF
    cnt = {{2{g[31]}}, g} - {{2{held_op_r[31]}}, held_op_r} + 34'sd1;
    if (cnt[33] || cnt == 34'sd0) begin
      cnt_sat = '0;
    end else if (cnt[32]) begin
      cnt_sat = '1;
    end else begin
      cnt_sat = cnt[31:0];
    end

    if (phase_r == PH_IDLE && left_r == 3'd0) begin
      // opcode byte
      start_nxt  = pos_r;
      op_nxt     = b;
      form_nxt   = cls.form;
      gather_nxt = '0;
      if (cls.form == F_TBLHDR || cls.form == F_LKPHDR) begin
        if (~pos_r[1:0] != 2'd0) begin
          phase_nxt = PH_PAD;
          pad_nxt   = ~pos_r[1:0];
        end else begin
          phase_nxt = PH_DEFAULT;
          left_nxt  = 3'd4;
        end
      end else if (cls.len == 3'd0) begin
        emit     = 1'b1;
        res.form = cls.form;
      end else begin
        left_nxt = cls.len;
      end
    end else if (phase_r == PH_PAD) begin
      // drop padding bytes
      pad_nxt = pad_r - 2'd1;
      if (pad_nxt == 2'd0) begin
        phase_nxt  = PH_DEFAULT;
        left_nxt   = 3'd4;
        gather_nxt = '0;
      end
    end else begin
      // operand byte: shift into the gather word
      gather_nxt = g;
      left_nxt   = left_dec;
      if (left_dec == 3'd0) begin
        case (phase_r)
          PH_IDLE: begin
            emit = 1'b1;
            case (form_r)
              F_BYTE: begin
                res.form      = F_BYTE;
                res.operand_a = (op_r == OP_BIPUSH) ? {{24{g[7]}}, g[7:0]} : {24'd0, g[7:0]};
              end
              F_POOL16: begin
                res.form      = F_POOL16;
                res.operand_a = {16'd0, g[15:0]};
              end
              F_IMM16: begin
                res.form      = F_IMM16;
                res.operand_a = {{16{g[15]}}, g[15:0]};
              end
              F_IINC: begin
                res.form      = F_IINC;
                res.operand_a = {24'd0, g[15:8]};
                res.operand_b = {{24{g[7]}}, g[7:0]};
              end
              F_BR16: begin
                res.form          = F_BR16;
                res.branch_target = start32 + {{16{g[15]}}, g[15:0]};
              end
              F_BR32: begin
                res.form          = F_BR32;
                res.branch_target = start32 + g;
              end
              F_IFACE: begin
                res.form      = F_IFACE;
                res.operand_a = {16'd0, g[31:16]};
                res.operand_b = {24'd0, g[15:8]};
              end
              default: begin
                res.form      = F_MULTI;
                res.operand_a = {16'd0, g[23:8]};
                res.operand_b = {24'd0, g[7:0]};
              end
            endcase
            phase_nxt = PH_IDLE;
            left_nxt  = 3'd0;
            pad_nxt   = 2'd0;
          end
          PH_DEFAULT: begin
            held_def_nxt = g;
            phase_nxt    = PH_LOW;
            left_nxt     = 3'd4;
            gather_nxt   = '0;
          end
          PH_LOW: begin
            held_op_nxt = g;
            if (form_r == F_TBLHDR) begin
              phase_nxt  = PH_HIGH;
              left_nxt   = 3'd4;
              gather_nxt = '0;
            end else begin
              emit              = 1'b1;
              res.form          = F_LKPHDR;
              res.operand_a     = g;
              res.branch_target = start32 + held_def_r;
              if (!g[31] && g != 32'd0) begin
                ent_left_nxt = g;
                form_nxt     = F_ENTRY;
                phase_nxt    = PH_LKP_KEY;
                left_nxt     = 3'd4;
                gather_nxt   = '0;
              end else begin
                ent_left_nxt = '0;
                phase_nxt    = PH_IDLE;
                left_nxt     = 3'd0;
                pad_nxt      = 2'd0;
              end
            end
          end
          PH_HIGH: begin
            emit              = 1'b1;
            res.form          = F_TBLHDR;
            res.operand_a     = held_op_r;
            res.operand_b     = g;
            res.branch_target = start32 + held_def_r;
            key_nxt           = held_op_r;
            ent_left_nxt      = cnt_sat;
            if (cnt_sat != 32'd0) begin
              form_nxt   = F_ENTRY;
              phase_nxt  = PH_TBL_OFS;
              left_nxt   = 3'd4;
              gather_nxt = '0;
            end else begin
              phase_nxt = PH_IDLE;
              left_nxt  = 3'd0;
              pad_nxt   = 2'd0;
            end
          end
          PH_LKP_KEY: begin
            key_nxt    = g;
            phase_nxt  = PH_LKP_OFS;
            left_nxt   = 3'd4;
            gather_nxt = '0;
          end
          default: begin
            // table or lookup entry offset
            emit              = 1'b1;
            res.form          = F_ENTRY;
            res.operand_a     = key_r;
            res.branch_target = start32 + g;
            if (phase_r == PH_TBL_OFS) begin
              key_nxt = key_r + 32'd1;
            end
            ent_left_nxt = ent_left_r - 32'd1;
            if (ent_left_nxt == 32'd0) begin
              phase_nxt = PH_IDLE;
              left_nxt  = 3'd0;
              pad_nxt   = 2'd0;
            end else begin
              phase_nxt  = (phase_r == PH_TBL_OFS) ? PH_TBL_OFS : PH_LKP_KEY;
              left_nxt   = 3'd4;
              gather_nxt = '0;
            end
          end
        endcase
      end
    end

    // end of code: flag an unfinished instruction, return to offset zero
    if (last) begin
      if (phase_nxt != PH_IDLE || left_nxt != 3'd0) begin
        if (!emit) begin
          emit     = 1'b1;
          res      = '0;
          res.form = form_nxt;
        end
        res.cut_short = 1'b1;
      end
      phase_nxt = PH_IDLE;
      left_nxt  = 3'd0;
      pad_nxt   = 2'd0;
      pos_nxt   = '0;
    end else begin
      pos_nxt = POS_BITS'(pos_r + 1'b1);
    end

    res.start_offset = 16'(start_nxt);
    res.opcode       = op_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      start_r     <= '0;
      op_r        <= '0;
      form_r      <= F_NONE;
      left_r      <= '0;
      pad_r       <= '0;
      gather_r    <= '0;
      held_op_r   <= '0;
      held_def_r  <= '0;
      ent_left_r  <= '0;
      key_r       <= '0;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r       <= pos_nxt;
        start_r     <= start_nxt;
        op_r        <= op_nxt;
        form_r      <= form_nxt;
        left_r      <= left_nxt;
        pad_r       <= pad_nxt;
        gather_r    <= gather_nxt;
        held_op_r   <= held_op_nxt;
        held_def_r  <= held_def_nxt;
        ent_left_r  <= ent_left_nxt;
        key_r       <= key_nxt;
        phase_r     <= phase_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the result payload until a new result replaces it
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_data_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== sim/jvm_bytecode_decoder_tb.sv =====
// Testbench of the bytecode decoder: byte stream stimulus, instruction predictor, result checks.
`default_nettype none
module jvm_bytecode_decoder_tb;
  import jvmbd_pkg::*;

  // Opcodes that bound the operand classes; the package only names a few of them.
  localparam logic [7:0] OP_NOP           = 8'h00;
  localparam logic [7:0] OP_DCONST_1      = 8'h0f;
  localparam logic [7:0] OP_LDC_W         = 8'h13;
  localparam logic [7:0] OP_LDC2_W        = 8'h14;
  localparam logic [7:0] OP_ILOAD         = 8'h15;
  localparam logic [7:0] OP_ALOAD         = 8'h19;
  localparam logic [7:0] OP_ILOAD_0       = 8'h1a;
  localparam logic [7:0] OP_SALOAD        = 8'h35;
  localparam logic [7:0] OP_ISTORE        = 8'h36;
  localparam logic [7:0] OP_ASTORE        = 8'h3a;
  localparam logic [7:0] OP_ISTORE_0      = 8'h3b;
  localparam logic [7:0] OP_LXOR          = 8'h83;
  localparam logic [7:0] OP_I2L           = 8'h85;
  localparam logic [7:0] OP_DCMPG         = 8'h98;
  localparam logic [7:0] OP_RET           = 8'ha9;
  localparam logic [7:0] OP_IRETURN       = 8'hac;
  localparam logic [7:0] OP_RETURN        = 8'hb1;
  localparam logic [7:0] OP_GETSTATIC     = 8'hb2;
  localparam logic [7:0] OP_INVOKESTATIC  = 8'hb8;
  localparam logic [7:0] OP_INVOKEDYNAMIC = 8'hba;
  localparam logic [7:0] OP_NEW           = 8'hbb;
  localparam logic [7:0] OP_ANEWARRAY     = 8'hbd;
  localparam logic [7:0] OP_ARRAYLENGTH   = 8'hbe;
  localparam logic [7:0] OP_ATHROW        = 8'hbf;
  localparam logic [7:0] OP_CHECKCAST     = 8'hc0;
  localparam logic [7:0] OP_INSTANCEOF    = 8'hc1;
  localparam logic [7:0] OP_MONITORENTER  = 8'hc2;
  localparam logic [7:0] OP_MONITOREXIT   = 8'hc3;
  localparam logic [7:0] OP_WIDE          = 8'hc4;
  localparam logic [7:0] OP_IFNULL        = 8'hc6;
  localparam logic [7:0] OP_IFNONNULL     = 8'hc7;
  localparam logic [7:0] OP_JSR_W         = 8'hc9;
  localparam logic [7:0] OP_IMPDEP2       = 8'hff;

  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] INT_MIN = 32'h8000_0000;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_data;

  jvm_bytecode_decoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Guard against a hung handshake.
  initial begin
    #6000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  int gap_pct    = 0;
  int stall_pct  = 0;
  int errors     = 0;
  int bytes_sent = 0;

  out_req_t   instr_results_q[$];
  logic [7:0] instr_bytes[$];

  // Predicted decoder state, reset values as after rst_n.
  logic [15:0] m_pos     = '0;
  logic [15:0] m_start   = '0;
  logic [7:0]  m_op      = '0;
  form_t       m_form    = F_NONE;
  logic [3:0]  m_left    = '0;
  logic [1:0]  m_pad     = '0;
  logic [31:0] m_word    = '0;
  logic [31:0] m_low     = '0;
  logic [31:0] m_dflt    = '0;
  logic [31:0] m_entries = '0;
  logic [31:0] m_key     = '0;
  phase_t      m_phase   = PH_IDLE;

  // Random receiver stalls.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [31:0] sx8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic cls_t classify(logic [7:0] op);
    cls_t c;
    c.len = 3'd0;
    if (op <= OP_DCONST_1 || (op >= OP_ILOAD_0 && op <= OP_SALOAD) ||
        (op >= OP_ISTORE_0 && op <= OP_LXOR) || (op >= OP_I2L && op <= OP_DCMPG) ||
        (op >= OP_IRETURN && op <= OP_RETURN) || op == OP_ARRAYLENGTH ||
        op == OP_ATHROW || op == OP_MONITORENTER || op == OP_MONITOREXIT) begin
      c.form = F_NONE;
    end else if (op == OP_BIPUSH || op == OP_LDC || (op >= OP_ILOAD && op <= OP_ALOAD) ||
                 (op >= OP_ISTORE && op <= OP_ASTORE) || op == OP_RET ||
                 op == OP_NEWARRAY) begin
      c.form = F_BYTE;
      c.len  = 3'd1;
    end else if (op == OP_SIPUSH) begin
      c.form = F_IMM16;
      c.len  = 3'd2;
    end else if (op == OP_LDC_W || op == OP_LDC2_W ||
                 (op >= OP_GETSTATIC && op <= OP_INVOKESTATIC) || op == OP_NEW ||
                 op == OP_ANEWARRAY || op == OP_CHECKCAST || op == OP_INSTANCEOF) begin
      c.form = F_POOL16;
      c.len  = 3'd2;
    end else if (op == OP_IINC) begin
      c.form = F_IINC;
      c.len  = 3'd2;
    end else if ((op >= OP_IFEQ && op <= OP_JSR) || op == OP_IFNULL || op == OP_IFNONNULL) begin
      c.form = F_BR16;
      c.len  = 3'd2;
    end else if (op == OP_GOTO_W || op == OP_JSR_W) begin
      c.form = F_BR32;
      c.len  = 3'd4;
    end else if (op == OP_INVOKEIFACE) begin
      c.form = F_IFACE;
      c.len  = 3'd4;
    end else if (op == OP_MULTIANEW) begin
      c.form = F_MULTI;
      c.len  = 3'd3;
    end else if (op == OP_TABLESWITCH) begin
      c.form = F_TBLHDR;
    end else if (op == OP_LOOKUPSWITCH) begin
      c.form = F_LKPHDR;
    end else begin
      c.form = F_UNKNOWN;
    end
    return c;
  endfunction

  function automatic out_req_t mk_result(form_t f, logic [31:0] a, logic [31:0] b,
                                         logic [31:0] tgt);
    out_req_t r;
    r.start_offset  = m_start;
    r.opcode        = m_op;
    r.form          = f;
    r.operand_a     = a;
    r.operand_b     = b;
    r.branch_target = tgt;
    r.cut_short     = 1'b0;
    return r;
  endfunction

  task automatic finish_instr();
    m_phase = PH_IDLE;
    m_left  = 4'd0;
    m_pad   = 2'd0;
  endtask

  task automatic start_word(input phase_t ph);
    m_phase = ph;
    m_left  = 4'd4;
    m_word  = '0;
  endtask

  task automatic begin_entries(input logic [31:0] count, input phase_t ph);
    m_entries = count;
    if (count == 32'd0) begin
      finish_instr();
    end else begin
      m_form = F_ENTRY;
      start_word(ph);
    end
  endtask

  task automatic entry_done();
    m_entries = m_entries - 32'd1;
    if (m_entries == 32'd0) finish_instr();
  endtask

  // Advance the predicted state by one accepted code byte and queue any result.
  task automatic decode_byte(input logic [7:0] b, input logic last);
    cls_t        cls;
    out_req_t    res;
    bit          got;
    logic [31:0] g;
    logic [31:0] base;
    logic [31:0] cnt;
    logic [1:0]  pad2;
    longint      span;
    got = 1'b0;
    res = '0;
    base = {16'd0, m_start};
    if (m_phase == PH_IDLE && m_left == 4'd0) begin
      cls     = classify(b);
      m_start = m_pos;
      m_op    = b;
      m_form  = cls.form;
      m_word  = '0;
      base    = {16'd0, m_start};
      if (m_form == F_TBLHDR || m_form == F_LKPHDR) begin
        pad2 = 2'd3 - m_pos[1:0];
        if (pad2 != 2'd0) begin
          m_phase = PH_PAD;
          m_pad   = pad2;
        end else begin
          start_word(PH_DEFAULT);
        end
      end else if (cls.len == 3'd0) begin
        res = mk_result(m_form, '0, '0, '0);
        got = 1'b1;
      end else begin
        m_left = {1'b0, cls.len};
      end
    end else if (m_phase == PH_PAD) begin
      m_pad = m_pad - 2'd1;
      if (m_pad == 2'd0) start_word(PH_DEFAULT);
    end else begin
      m_word = {m_word[23:0], b};
      m_left = m_left - 4'd1;
      if (m_left == 4'd0) begin
        g = m_word;
        case (m_phase)
          PH_IDLE: begin
            case (m_form)
              F_BYTE: res = mk_result(F_BYTE, (m_op == OP_BIPUSH) ? sx8(g[7:0])
                                                                   : {24'd0, g[7:0]}, '0, '0);
              F_POOL16: res = mk_result(F_POOL16, {16'd0, g[15:0]}, '0, '0);
              F_IMM16:  res = mk_result(F_IMM16, sx16(g[15:0]), '0, '0);
              F_IINC:   res = mk_result(F_IINC, {24'd0, g[15:8]}, sx8(g[7:0]), '0);
              F_BR16:   res = mk_result(F_BR16, '0, '0, base + sx16(g[15:0]));
              F_BR32:   res = mk_result(F_BR32, '0, '0, base + g);
              F_IFACE:  res = mk_result(F_IFACE, {16'd0, g[31:16]}, {24'd0, g[15:8]}, '0);
              default:  res = mk_result(F_MULTI, {16'd0, g[23:8]}, {24'd0, g[7:0]}, '0);
            endcase
            got = 1'b1;
            finish_instr();
          end
          PH_DEFAULT: begin
            m_dflt = g;
            start_word(PH_LOW);
          end
          PH_LOW: begin
            m_low = g;
            if (m_form == F_TBLHDR) begin
              start_word(PH_HIGH);
            end else begin
              res = mk_result(F_LKPHDR, g, '0, base + m_dflt);
              got = 1'b1;
              // Drop the entries of a lookup with zero or negative npairs.
              begin_entries((int'(g) > 0) ? g : 32'd0, PH_LKP_KEY);
            end
          end
          PH_HIGH: begin
            // Count entries in 64 bits so an inverted or full-range table is exact.
            span = longint'(int'(g)) - longint'(int'(m_low)) + 64'sd1;
            cnt = (span <= 0) ? 32'd0 :
                  (span > 64'sh0_ffff_ffff) ? 32'hffff_ffff : span[31:0];
            res = mk_result(F_TBLHDR, m_low, g, base + m_dflt);
            got = 1'b1;
            m_key = m_low;
            begin_entries(cnt, PH_TBL_OFS);
          end
          PH_TBL_OFS: begin
            res = mk_result(F_ENTRY, m_key, '0, base + g);
            got = 1'b1;
            m_key = m_key + 32'd1;
            entry_done();
            if (m_phase != PH_IDLE) start_word(PH_TBL_OFS);
          end
          PH_LKP_KEY: begin
            m_key = g;
            start_word(PH_LKP_OFS);
          end
          default: begin
            res = mk_result(F_ENTRY, m_key, '0, base + g);
            got = 1'b1;
            entry_done();
            if (m_phase != PH_IDLE) start_word(PH_LKP_KEY);
          end
        endcase
      end
    end
    // End of code: flag an unfinished instruction, then rewind the offset.
    if (last) begin
      if (m_phase != PH_IDLE || m_left != 4'd0) begin
        if (!got) begin
          res = mk_result(m_form, '0, '0, '0);
          got = 1'b1;
        end
        res.cut_short = 1'b1;
      end
      finish_instr();
      m_pos = '0;
    end else begin
      m_pos = m_pos + 16'd1;
    end
    if (got) instr_results_q.insert(instr_results_q.size(), res);
  endtask

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check_result
    out_req_t want;
    if (rst_n && out_valid && out_ready) begin
      if (instr_results_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: offset %h op %h form %0d",
                   out_data.start_offset, out_data.opcode, out_data.form);
      end else begin
        want = instr_results_q.pop_front();
        if (out_data !== want) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected offset %h op %h form %0d a %h b %h tgt %h cut %b",
                     want.start_offset, want.opcode, want.form, want.operand_a,
                     want.operand_b, want.branch_target, want.cut_short);
            $display("          got      offset %h op %h form %0d a %h b %h tgt %h cut %b",
                     out_data.start_offset, out_data.opcode, out_data.form,
                     out_data.operand_a, out_data.operand_b, out_data.branch_target,
                     out_data.cut_short);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // Send one code byte; hold valid and payload until the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, last};
    do @(posedge clk); while (!in_ready);
    decode_byte(b, last);
    bytes_sent++;
  endtask

  // Hold off the sender until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (instr_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Send the queued method; end the code at byte cut_at, or at its last byte.
  task automatic send_method(input int cut_at);
    int fin;
    int i;
    fin = (cut_at < 0 || cut_at >= instr_bytes.size()) ? instr_bytes.size() - 1 : cut_at;
    for (i = 0; i <= fin; i++) send_byte(instr_bytes[i], i == fin);
    instr_bytes.delete();
  endtask

  // Append one byte to the method being built.
  task automatic add_byte(input logic [7:0] v);
    instr_bytes.insert(instr_bytes.size(), v);
  endtask

  function automatic logic [7:0] rand_byte();
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0:       return 8'h00;
        1:       return 8'h7f;
        2:       return 8'h80;
        default: return 8'hff;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [31:0] rand_word();
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(3))
        0:       return 32'd0;
        1:       return INT_MAX;
        2:       return INT_MIN;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [7:0] pick_opcode(form_t f);
    logic [7:0] op;
    cls_t       c;
    do begin
      op = 8'($urandom_range(255));
      c  = classify(op);
    end while (c.form != f);
    return op;
  endfunction

  task automatic push_word(input logic [31:0] w);
    add_byte(w[31:24]);
    add_byte(w[23:16]);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
  endtask

  // Pad to the next 4-byte boundary, counted from the opcode's offset in the code.
  task automatic push_pad();
    logic [15:0] pos;
    pos = m_pos + 16'(instr_bytes.size()) - 16'd1;
    repeat (3 - int'(pos[1:0])) add_byte(rand_byte());
  endtask

  task automatic push_table(input logic [31:0] dflt, input logic [31:0] lo,
                            input logic [31:0] hi, input int n_entries);
    add_byte(OP_TABLESWITCH);
    push_pad();
    push_word(dflt);
    push_word(lo);
    push_word(hi);
    repeat (n_entries) push_word(rand_word());
  endtask

  task automatic push_lookup(input logic [31:0] dflt, input logic [31:0] npairs,
                             input int n_pairs);
    add_byte(OP_LOOKUPSWITCH);
    push_pad();
    push_word(dflt);
    push_word(npairs);
    repeat (n_pairs) begin
      push_word(rand_word());
      push_word(rand_word());
    end
  endtask

  // Queue one well-formed instruction of a random form with random operands.
  task automatic push_random_instr();
    int          w;
    int          k;
    form_t       f;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] np;
    cls_t        c;
    w = $urandom_range(99);
    if (w < 18)      f = F_NONE;
    else if (w < 28) f = F_BYTE;
    else if (w < 36) f = F_POOL16;
    else if (w < 41) f = F_IMM16;
    else if (w < 47) f = F_IINC;
    else if (w < 57) f = F_BR16;
    else if (w < 62) f = F_BR32;
    else if (w < 67) f = F_IFACE;
    else if (w < 72) f = F_MULTI;
    else if (w < 78) f = F_UNKNOWN;
    else if (w < 89) f = F_TBLHDR;
    else             f = F_LKPHDR;
    case (f)
      F_TBLHDR: begin
        k = $urandom_range(4);
        case ($urandom_range(9))
          0:       lo = INT_MAX - 32'd3;
          1:       lo = INT_MIN;
          default: lo = 32'($urandom_range(2000)) - 32'd1000;
        endcase
        if (k == 0 && lo == INT_MIN) k = 1;
        hi = (k == 0) ? lo - 32'd1 - 32'($urandom_range(50)) : lo + 32'(k) - 32'd1;
        push_table(rand_word(), lo, hi, k);
      end
      F_LKPHDR: begin
        k = $urandom_range(4);
        np = 32'(k);
        if ($urandom_range(9) == 0) begin
          np = INT_MIN | $urandom();
          k  = 0;
        end
        push_lookup(rand_word(), np, k);
      end
      default: begin
        add_byte(pick_opcode(f));
        c = classify(instr_bytes[instr_bytes.size() - 1]);
        repeat (int'(c.len)) add_byte(rand_byte());
      end
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  // Every fixed-length form, with sign and range extremes of its operands.
  task automatic test_operand_forms();
    gap_pct   = 0;
    stall_pct = 0;
    instr_bytes = '{OP_NOP, OP_BIPUSH, 8'h80, OP_BIPUSH, 8'h7f, OP_LDC, 8'hff,
                    OP_SIPUSH, 8'h80, 8'h00, OP_SIPUSH, 8'h7f, 8'hff,
                    OP_LDC_W, 8'hff, 8'hff, OP_IINC, 8'hff, 8'h80, OP_IINC, 8'h00, 8'h7f,
                    OP_IFEQ, 8'h80, 8'h00, OP_JSR, 8'h7f, 8'hff,
                    OP_GOTO_W, 8'h80, 8'h00, 8'h00, 8'h00,
                    OP_JSR_W, 8'h7f, 8'hff, 8'hff, 8'hff,
                    OP_INVOKEIFACE, 8'hff, 8'hff, 8'hff, 8'h00,
                    OP_MULTIANEW, 8'hff, 8'hff, 8'hff, OP_NEWARRAY, 8'h0a,
                    OP_INVOKEDYNAMIC, OP_WIDE, OP_IMPDEP2, OP_RETURN};
    send_method(-1);
    wait_drained();
  endtask

  // Both switches at every padding, with empty, negative and extreme bounds.
  task automatic test_switches();
    gap_pct   = 0;
    stall_pct = 37;
    push_table(32'hffff_ff00, 32'hffff_ffff, 32'd1, 3);
    add_byte(OP_NOP);
    push_lookup(32'h0000_0010, 32'd2, 2);
    repeat (2) add_byte(OP_NOP);
    push_table(INT_MAX, 32'd5, 32'd4, 0);
    repeat (3) add_byte(OP_NOP);
    push_lookup(INT_MIN, 32'd0, 0);
    push_lookup(32'd0, INT_MIN, 0);
    push_table(32'd0, INT_MAX, INT_MAX, 1);
    add_byte(OP_NOP);
    push_table(32'd4, INT_MIN, INT_MIN + 32'd1, 2);
    add_byte(OP_NOP);
    send_method(-1);
    wait_drained();
  endtask

  // Code that ends inside an instruction, at each kind of point.
  task automatic test_cut_short();
    gap_pct   = 37;
    stall_pct = 37;
    instr_bytes = '{OP_SIPUSH};
    send_method(-1);
    instr_bytes = '{OP_GOTO_W, 8'h00, 8'h01, 8'h02, 8'h03};
    send_method(2);
    push_table(32'd0, 32'd0, 32'd0, 1);
    send_method(0);
    add_byte(OP_NOP);
    push_table(32'd0, 32'd0, 32'd0, 1);
    send_method(2);
    // Header completes on the final byte while its entries are still owed.
    push_lookup(32'd8, 32'd2, 2);
    send_method(instr_bytes.size() - 17);
    // Full-range table: saturated entry count, cut after two entries.
    push_table(32'd12, INT_MIN, INT_MAX, 2);
    send_method(-1);
    push_lookup(32'd0, 32'd1, 1);
    send_method(instr_bytes.size() - 5);
    wait_drained();
  endtask

  // Random methods, mostly well formed, some cut short, some raw noise.
  task automatic test_random_stream();
    int gap_set[4]   = '{0, 60, 0, 37};
    int stall_set[4] = '{0, 0, 60, 37};
    int p;
    int kind;
    int cut;
    int first;
    for (p = 0; p < 4; p++) begin
      gap_pct   = gap_set[p];
      stall_pct = stall_set[p];
      first = bytes_sent;
      while (bytes_sent - first < 410) begin
        kind = $urandom_range(99);
        cut  = -1;
        if (kind < 15) begin
          repeat ($urandom_range(24, 1)) add_byte(8'($urandom_range(255)));
        end else begin
          repeat ($urandom_range(10, 1)) push_random_instr();
          if (kind < 30) cut = $urandom_range(instr_bytes.size() - 1);
        end
        send_method(cut);
        if ($urandom_range(19) == 0) wait_drained();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_operand_forms();
    test_switches();
    test_cut_short();
    test_random_stream();
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0 && instr_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/jvmbd_pkg.sv
rtl/core/jvm_bytecode_decoder.sv
sim/jvm_bytecode_decoder_tb.sv
